@@ design/pcpt_pkg.sv @@
// Shared types and constants for the online perceptron trainer.
// No dependencies; every other design file refers to this package by scoped names.
package pcpt_pkg;

    localparam int NUM_INPUTS    = 8;
    localparam int FEAT_W        = 24;
    localparam int VAL_W         = 40;
    localparam int LR_W          = 16;
    localparam int LR_FRAC       = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [LR_W-1:0] LR_RESET = 16'd655;

    // Each weight is split into a signed upper half and an unsigned lower half so that
    // every lane multiplier stays near 20 x 24 bits.
    localparam int LO_W     = 20;
    localparam int HI_W     = VAL_W - LO_W;
    localparam int PH_W     = HI_W + FEAT_W;
    localparam int PL_W     = LO_W + 1 + FEAT_W;
    localparam int PAIRS    = NUM_INPUTS / 2;
    localparam int PH_SUM_W = PH_W + $clog2(NUM_INPUTS);
    localparam int PL_SUM_W = PL_W + $clog2(NUM_INPUTS);
    localparam int ACC_W    = PH_SUM_W + LO_W + 2;

    typedef struct packed {
        logic signed [FEAT_W-1:0] feature_0;
        logic signed [FEAT_W-1:0] feature_1;
        logic signed [FEAT_W-1:0] feature_2;
        logic signed [FEAT_W-1:0] feature_3;
        logic signed [FEAT_W-1:0] feature_4;
        logic signed [FEAT_W-1:0] feature_5;
        logic signed [FEAT_W-1:0] feature_6;
        logic signed [FEAT_W-1:0] feature_7;
        logic                     target_class;
    } pcpt_in_t;

    typedef struct packed {
        logic                    predicted_class;
        logic                    misclassified;
        logic signed [VAL_W-1:0] weight_out_0;
        logic signed [VAL_W-1:0] weight_out_1;
        logic signed [VAL_W-1:0] weight_out_2;
        logic signed [VAL_W-1:0] weight_out_3;
        logic signed [VAL_W-1:0] weight_out_4;
        logic signed [VAL_W-1:0] weight_out_5;
        logic signed [VAL_W-1:0] weight_out_6;
        logic signed [VAL_W-1:0] weight_out_7;
        logic signed [VAL_W-1:0] bias_out;
    } pcpt_out_t;

    // Pipeline strobes from the sequencer in the top level.
    typedef struct packed {
        logic start;
        logic stage2;
        logic stage3;
        logic commit;
        logic target;
    } pcpt_ctl_t;

    // Update decision from the merging stage to the lanes.
    typedef struct packed {
        logic apply;
        logic up;
    } pcpt_upd_t;

endpackage

@@ design/perceptron_online_trainer_core.sv @@
// Top level of the online perceptron trainer: request buffering, pipeline sequencing,
// learning-rate register and result register. Uses pcpt_pkg, pcpt_lane and pcpt_merge.
//
// The block starts a new request only after the previous one has committed its result.
// This limit is set by the weight feedback loop: the lane multipliers, two adder-tree
// stages and the decision with weight write-back must finish before the next request
// may read the weights, and the commit itself waits while the consumer stalls a full
// result register. A one-entry input buffer accepts the next request while the
// current one is in the pipeline, and a result register holds a finished result while
// the consumer stalls. After reset all weights and the bias are zero and the learning
// rate is 655 (about 0.01 in Q0.16).
module perceptron_online_trainer_core #(
    parameter int FRAC_BITS = pcpt_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pcpt_pkg::pcpt_in_t            sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pcpt_pkg::pcpt_out_t           result,
    input  logic                          cfg_we,
    input  logic [pcpt_pkg::LR_W-1:0]     cfg_wdata
);

    localparam int NUM = pcpt_pkg::NUM_INPUTS;

    pcpt_pkg::pcpt_in_t               in_reg;
    logic                             in_valid_reg;
    logic                             v1_reg;
    logic                             v2_reg;
    logic                             v3_reg;
    logic                             target_reg;
    logic [pcpt_pkg::LR_W-1:0]        learn_rate_reg;
    pcpt_pkg::pcpt_out_t              out_reg;
    logic                             out_valid_reg;
    pcpt_pkg::pcpt_ctl_t              ctl;
    pcpt_pkg::pcpt_upd_t              upd;
    logic                             pred;
    logic signed [pcpt_pkg::VAL_W-1:0]  bias_upd;
    logic signed [pcpt_pkg::FEAT_W-1:0] feat [NUM];
    logic signed [pcpt_pkg::PH_W-1:0]   ph [NUM];
    logic signed [pcpt_pkg::PL_W-1:0]   pl [NUM];
    logic signed [pcpt_pkg::VAL_W-1:0]  w_upd [NUM];

    assign feat[0] = in_reg.feature_0;
    assign feat[1] = in_reg.feature_1;
    assign feat[2] = in_reg.feature_2;
    assign feat[3] = in_reg.feature_3;
    assign feat[4] = in_reg.feature_4;
    assign feat[5] = in_reg.feature_5;
    assign feat[6] = in_reg.feature_6;
    assign feat[7] = in_reg.feature_7;

    // Only one request is in the pipeline at a time, so the stages never collide.
    always_comb
    begin
        ctl.start  = in_valid_reg && !v1_reg && !v2_reg && !v3_reg;
        ctl.stage2 = v1_reg;
        ctl.stage3 = v2_reg;
        ctl.commit = v3_reg && (!out_valid_reg || out_ready);
        ctl.target = target_reg;
    end

    assign in_ready  = !in_valid_reg || ctl.start;
    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            learn_rate_reg <= pcpt_pkg::LR_RESET;
        end
        else
        begin
            if (in_valid && in_ready)
                in_valid_reg <= 1'b1;
            else if (ctl.start)
                in_valid_reg <= 1'b0;
            v1_reg <= ctl.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg || (v3_reg && !ctl.commit);
            if (ctl.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
                learn_rate_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_reg <= sample;
        if (ctl.start)
            target_reg <= in_reg.target_class;
        if (ctl.commit)
        begin
            out_reg.predicted_class <= pred;
            out_reg.misclassified   <= upd.apply;
            out_reg.weight_out_0    <= w_upd[0];
            out_reg.weight_out_1    <= w_upd[1];
            out_reg.weight_out_2    <= w_upd[2];
            out_reg.weight_out_3    <= w_upd[3];
            out_reg.weight_out_4    <= w_upd[4];
            out_reg.weight_out_5    <= w_upd[5];
            out_reg.weight_out_6    <= w_upd[6];
            out_reg.weight_out_7    <= w_upd[7];
            out_reg.bias_out        <= bias_upd;
        end
    end

    for (genvar i = 0; i < NUM; i++)
    begin : g_lane
        pcpt_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .upd        (upd),
            .learn_rate (learn_rate_reg),
            .feature    (feat[i]),
            .ph         (ph[i]),
            .pl         (pl[i]),
            .weight_upd (w_upd[i])
        );
    end

    pcpt_merge #(
        .FRAC_BITS(FRAC_BITS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .learn_rate (learn_rate_reg),
        .ph         (ph),
        .pl         (pl),
        .upd        (upd),
        .pred       (pred),
        .bias_upd   (bias_upd)
    );

endmodule

@@ design/pcpt_lane.sv @@
// One weight lane: owns its weight, forms the partial products of the dot product,
// and prepares the saturated weight for both update directions. Uses pcpt_pkg.
module pcpt_lane #(
    parameter int FRAC_BITS = pcpt_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pcpt_pkg::pcpt_ctl_t                    ctl,
    input  pcpt_pkg::pcpt_upd_t                    upd,
    input  logic [pcpt_pkg::LR_W-1:0]              learn_rate,
    input  logic signed [pcpt_pkg::FEAT_W-1:0]     feature,
    output logic signed [pcpt_pkg::PH_W-1:0]       ph,
    output logic signed [pcpt_pkg::PL_W-1:0]       pl,
    output logic signed [pcpt_pkg::VAL_W-1:0]      weight_upd
);

    localparam int VAL_W    = pcpt_pkg::VAL_W;
    localparam int LO_W     = pcpt_pkg::LO_W;
    localparam int UP_SH    = (FRAC_BITS > pcpt_pkg::LR_FRAC) ? FRAC_BITS - pcpt_pkg::LR_FRAC : 0;
    localparam int DN_SH    = (FRAC_BITS < pcpt_pkg::LR_FRAC) ? pcpt_pkg::LR_FRAC - FRAC_BITS : 0;
    localparam int RAW_W    = pcpt_pkg::LR_W + 1 + pcpt_pkg::FEAT_W;
    localparam int STEP_W   = RAW_W + UP_SH;
    localparam int SUM_W    = STEP_W + 2;

    logic signed [VAL_W-1:0]          weight_reg;
    logic signed [pcpt_pkg::PH_W-1:0] ph_reg;
    logic signed [pcpt_pkg::PL_W-1:0] pl_reg;
    logic signed [RAW_W-1:0]          step_raw_reg;
    logic signed [VAL_W-1:0]          wplus_reg;
    logic signed [VAL_W-1:0]          wminus_reg;
    logic signed [STEP_W-1:0]         step_ext;
    logic signed [STEP_W-1:0]         step;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-VAL_W:0] top_bits;
        top_bits = v[SUM_W-1:VAL_W-1];
        if (top_bits == '0 || top_bits == '1)
            return v[VAL_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(VAL_W-1){1'b0}}};
        else
            return {1'b0, {(VAL_W-1){1'b1}}};
    endfunction

    // Scaling from Q.16 to the weight format; the right shift floors, as intended.
    assign step_ext = STEP_W'(step_raw_reg);
    assign step     = (step_ext <<< UP_SH) >>> DN_SH;

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            ph_reg       <= $signed(weight_reg[VAL_W-1:LO_W]) * feature;
            pl_reg       <= $signed({1'b0, weight_reg[LO_W-1:0]}) * feature;
            step_raw_reg <= $signed({1'b0, learn_rate}) * feature;
        end
        if (ctl.stage2)
        begin
            wplus_reg  <= sat_val(SUM_W'(weight_reg) + SUM_W'(step));
            wminus_reg <= sat_val(SUM_W'(weight_reg) - SUM_W'(step));
        end
    end

    assign weight_upd = upd.apply ? (upd.up ? wplus_reg : wminus_reg) : weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weight_reg <= '0;
        else if (ctl.commit)
            weight_reg <= weight_upd;
    end

    assign ph = ph_reg;
    assign pl = pl_reg;

endmodule

@@ design/pcpt_merge.sv @@
// Merging stage: registered adder tree over the lane partial products, bias
// handling and the class decision that drives the weight update. Uses pcpt_pkg.
module pcpt_merge #(
    parameter int FRAC_BITS = pcpt_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pcpt_pkg::pcpt_ctl_t                ctl,
    input  logic [pcpt_pkg::LR_W-1:0]          learn_rate,
    input  logic signed [pcpt_pkg::PH_W-1:0]   ph [pcpt_pkg::NUM_INPUTS],
    input  logic signed [pcpt_pkg::PL_W-1:0]   pl [pcpt_pkg::NUM_INPUTS],
    output pcpt_pkg::pcpt_upd_t                upd,
    output logic                               pred,
    output logic signed [pcpt_pkg::VAL_W-1:0]  bias_upd
);

    localparam int VAL_W    = pcpt_pkg::VAL_W;
    localparam int PH_W     = pcpt_pkg::PH_W;
    localparam int PL_W     = pcpt_pkg::PL_W;
    localparam int PAIRS    = pcpt_pkg::PAIRS;
    localparam int PH_SUM_W = pcpt_pkg::PH_SUM_W;
    localparam int PL_SUM_W = pcpt_pkg::PL_SUM_W;
    localparam int ACC_W    = pcpt_pkg::ACC_W;
    localparam int UP_SH    = (FRAC_BITS > pcpt_pkg::LR_FRAC) ? FRAC_BITS - pcpt_pkg::LR_FRAC : 0;
    localparam int DN_SH    = (FRAC_BITS < pcpt_pkg::LR_FRAC) ? pcpt_pkg::LR_FRAC - FRAC_BITS : 0;
    localparam int DB_W     = pcpt_pkg::LR_W + UP_SH;
    localparam int BSUM_W   = VAL_W + 1;

    logic signed [PH_W:0]          pair_ph_reg [PAIRS];
    logic signed [PL_W:0]          pair_pl_reg [PAIRS];
    logic signed [PH_SUM_W-1:0]    tot_ph_reg;
    logic signed [PL_SUM_W-1:0]    tot_pl_reg;
    logic signed [PH_SUM_W-1:0]    tot_ph_next;
    logic signed [PL_SUM_W-1:0]    tot_pl_next;
    logic signed [VAL_W-1:0]       bias_reg;
    logic signed [VAL_W-1:0]       bplus_reg;
    logic signed [VAL_W-1:0]       bminus_reg;
    logic [DB_W-1:0]               db;
    logic signed [BSUM_W-1:0]      db_ext;
    logic signed [ACC_W-1:0]       acc;
    logic                          wrong;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [BSUM_W-1:0] v);
        logic [BSUM_W-VAL_W:0] top_bits;
        top_bits = v[BSUM_W-1:VAL_W-1];
        if (top_bits == '0 || top_bits == '1)
            return v[VAL_W-1:0];
        else if (v[BSUM_W-1])
            return {1'b1, {(VAL_W-1){1'b0}}};
        else
            return {1'b0, {(VAL_W-1){1'b1}}};
    endfunction

    assign db     = (DB_W'(learn_rate) << UP_SH) >> DN_SH;
    assign db_ext = BSUM_W'($signed({1'b0, db}));

    always_comb
    begin
        tot_ph_next = '0;
        tot_pl_next = '0;
        for (int k = 0; k < PAIRS; k++)
        begin
            tot_ph_next = tot_ph_next + PH_SUM_W'(pair_ph_reg[k]);
            tot_pl_next = tot_pl_next + PL_SUM_W'(pair_pl_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.stage2)
        begin
            for (int k = 0; k < PAIRS; k++)
            begin
                pair_ph_reg[k] <= (PH_W+1)'(ph[2*k]) + (PH_W+1)'(ph[2*k+1]);
                pair_pl_reg[k] <= (PL_W+1)'(pl[2*k]) + (PL_W+1)'(pl[2*k+1]);
            end
            bplus_reg  <= sat_val(BSUM_W'(bias_reg) + db_ext);
            bminus_reg <= sat_val(BSUM_W'(bias_reg) - db_ext);
        end
        if (ctl.stage3)
        begin
            tot_ph_reg <= tot_ph_next;
            tot_pl_reg <= tot_pl_next;
        end
    end

    // The upper-half partial sum carries a weight of 2^LO_W.
    assign acc   = (ACC_W'(tot_ph_reg) <<< pcpt_pkg::LO_W) + ACC_W'(tot_pl_reg)
                   + ACC_W'(bias_reg);
    assign pred  = ~acc[ACC_W-1];
    assign wrong = pred ^ ctl.target;

    assign upd.apply = wrong;
    assign upd.up    = ctl.target;
    assign bias_upd  = wrong ? (ctl.target ? bplus_reg : bminus_reg) : bias_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bias_reg <= '0;
        else if (ctl.commit)
            bias_reg <= bias_upd;
    end

endmodule

@@ design/pcpt_checker.sv @@
// Port-level checks for the online perceptron trainer, bound to the top level.
// Depends on pcpt_pkg and perceptron_online_trainer_core.
module pcpt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input pcpt_pkg::pcpt_out_t result
);

    logic [2:0]                        pending_reg;
    logic signed [pcpt_pkg::VAL_W-1:0] prev_bias_reg;
    logic signed [pcpt_pkg::VAL_W-1:0] prev_w0_reg;
    logic                              in_acc;
    logic                              out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Track requests in flight and the bias and weight 0 of the last delivered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            prev_bias_reg <= '0;
            prev_w0_reg   <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(in_acc) - 3'(out_acc);
            if (out_acc)
            begin
                prev_bias_reg <= result.bias_out;
                prev_w0_reg   <= result.weight_out_0;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without a pending request");

    a_correct_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !result.misclassified |->
            result.bias_out == prev_bias_reg && result.weight_out_0 == prev_w0_reg)
        else $error("parameters changed on a correct prediction");

    a_bias_direction: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && result.misclassified |->
            (result.predicted_class && result.bias_out <= prev_bias_reg) ||
            (!result.predicted_class && result.bias_out >= prev_bias_reg))
        else $error("bias moved against the error");

endmodule

bind perceptron_online_trainer_core pcpt_checker u_pcpt_checker (.*);

@@ verif/testbench.sv @@
// Self-checking testbench for perceptron_online_trainer_core: a clocked driver and
// monitor around a bit-exact training predictor. Depends on pcpt_pkg and the core RTL.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FEAT_W     = pcpt_pkg::FEAT_W;
    localparam int VAL_W      = pcpt_pkg::VAL_W;
    localparam int LR_W       = pcpt_pkg::LR_W;
    localparam int NUM_INPUTS = pcpt_pkg::NUM_INPUTS;

    typedef logic signed [FEAT_W-1:0] feat_t;
    typedef logic signed [VAL_W-1:0]  val_t;

    localparam feat_t  FEAT_MAX       = 24'sh7FFFFF;
    localparam feat_t  FEAT_MIN       = 24'sh800000;
    localparam longint VAL_HI         = (longint'(1) <<< (VAL_W - 1)) - 1;
    localparam longint VAL_LO         = -(longint'(1) <<< (VAL_W - 1));
    localparam int     HOLD_OFF       = 150;
    localparam int     WATCHDOG_LIMIT = 2000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    pcpt_pkg::pcpt_in_t    sample    = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    pcpt_pkg::pcpt_out_t   result;
    logic                  cfg_we    = 1'b0;
    logic [LR_W-1:0]       cfg_wdata = '0;

    // Trainer state as the predictor sees it.
    val_t              weight_model [NUM_INPUTS];
    val_t              bias_model = '0;
    logic [LR_W-1:0]   rate_model = pcpt_pkg::LR_RESET;

    pcpt_pkg::pcpt_in_t  sample_queue [$];
    pcpt_pkg::pcpt_out_t expected_outcomes [$];
    int                issued_total   = 0;
    int                accepted_total = 0;
    int                fault_count    = 0;
    int                tx_wait        = 0;
    int                rx_wait        = 0;
    int                hold_left      = 0;
    int                stall_request  = 0;
    int                stall_served   = 0;
    int                idle_cycles    = 0;
    bit                steady         = 1'b0;

    perceptron_online_trainer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic feat_t feature_of(pcpt_pkg::pcpt_in_t s, int i);
        return s[1 + FEAT_W * (NUM_INPUTS - 1 - i) +: FEAT_W];
    endfunction

    function automatic pcpt_pkg::pcpt_in_t make_sample(input feat_t lanes [NUM_INPUTS],
                                                        logic target);
        pcpt_pkg::pcpt_in_t s;
        for (int i = 0; i < NUM_INPUTS; i++)
            s[1 + FEAT_W * (NUM_INPUTS - 1 - i) +: FEAT_W] = lanes[i];
        s.target_class = target;
        return s;
    endfunction

    function automatic val_t clamp(longint v);
        if (v > VAL_HI)
            return VAL_HI[VAL_W-1:0];
        if (v < VAL_LO)
            return VAL_LO[VAL_W-1:0];
        return v[VAL_W-1:0];
    endfunction

    // The dot product needs more than 64 bits; each product alone fits in a longint.
    function automatic logic class_of(pcpt_pkg::pcpt_in_t s);
        logic signed [79:0] acc;
        acc = 80'(bias_model);
        for (int i = 0; i < NUM_INPUTS; i++)
            acc = acc + 80'(longint'(weight_model[i]) * longint'(feature_of(s, i)));
        return !acc[79];
    endfunction

    // One online training step. With 16 fraction bits the rate product needs no rescaling.
    function automatic void train_step(pcpt_pkg::pcpt_in_t s);
        pcpt_pkg::pcpt_out_t want;
        logic      pred;
        logic      wrong;
        longint    delta;
        pred  = class_of(s);
        wrong = pred != s.target_class;
        if (wrong)
        begin
            for (int i = 0; i < NUM_INPUTS; i++)
            begin
                delta = longint'(rate_model) * longint'(feature_of(s, i));
                weight_model[i] = clamp(s.target_class ? weight_model[i] + delta
                                                       : weight_model[i] - delta);
            end
            bias_model = clamp(s.target_class ? bias_model + longint'(rate_model)
                                               : bias_model - longint'(rate_model));
        end
        want.predicted_class = pred;
        want.misclassified   = wrong;
        for (int i = 0; i < NUM_INPUTS; i++)
            want[VAL_W * (NUM_INPUTS - i) +: VAL_W] = weight_model[i];
        want.bias_out = bias_model;
        expected_outcomes.push_back(want);
    endfunction

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic pcpt_pkg::pcpt_in_t random_sample();
        feat_t lanes [NUM_INPUTS];
        int    style;
        style = $urandom_range(0, 9);
        for (int i = 0; i < NUM_INPUTS; i++)
        begin
            if (style <= 4)
                lanes[i] = feat_t'($urandom());
            else if (style <= 7)
                lanes[i] = feat_t'(int'($urandom_range(0, 64)) - 32);
            else if (style == 8)
            begin
                case ($urandom_range(0, 3))
                    0: lanes[i] = FEAT_MAX;
                    1: lanes[i] = FEAT_MIN;
                    2: lanes[i] = '0;
                    default: lanes[i] = feat_t'(-1);
                endcase
            end
            else
                lanes[i] = ($urandom_range(0, 7) == 0) ? feat_t'($urandom()) : feat_t'(0);
        end
        return make_sample(lanes, 1'($urandom_range(0, 1)));
    endfunction

    task automatic report(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    task automatic check_outcome(pcpt_pkg::pcpt_out_t got);
        pcpt_pkg::pcpt_out_t want;
        if (expected_outcomes.size() == 0)
        begin
            report("result with no request outstanding, bias_out", '0, got.bias_out);
            return;
        end
        want = expected_outcomes.pop_front();
        if (got.predicted_class !== want.predicted_class)
            report("predicted_class", VAL_W'(want.predicted_class),
                   VAL_W'(got.predicted_class));
        if (got.misclassified !== want.misclassified)
            report("misclassified", VAL_W'(want.misclassified), VAL_W'(got.misclassified));
        for (int i = 0; i <= NUM_INPUTS; i++)
        begin
            if (got[VAL_W * (NUM_INPUTS - i) +: VAL_W] !== want[VAL_W * (NUM_INPUTS - i) +: VAL_W])
                report(i == NUM_INPUTS ? "bias_out" : $sformatf("weight_out_%0d", i),
                       want[VAL_W * (NUM_INPUTS - i) +: VAL_W],
                       got[VAL_W * (NUM_INPUTS - i) +: VAL_W]);
        end
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                train_step(sample);
                accepted_total++;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (sample_queue.size() != 0)
                begin
                    sample   <= sample_queue.pop_front();
                    in_valid <= 1'b1;
                    tx_wait = draw_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor; it also owns out_ready, including the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_outcome(result);
                rx_wait = draw_gap();
            end
            if (stall_request != stall_served)
            begin
                stall_served = stall_request;
                hold_left = HOLD_OFF;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Only counts while some request or result is still owed.
    always @(posedge clk)
    begin
        if (!rst_n || (accepted_total == issued_total && expected_outcomes.size() == 0)
            || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles++;
    end

    task automatic send(pcpt_pkg::pcpt_in_t s);
        sample_queue.push_back(s);
        issued_total++;
    endtask

    task automatic drain();
        while (accepted_total != issued_total || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_rate(logic [LR_W-1:0] rate);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= rate;
        @(posedge clk);
        cfg_we    <= 1'b0;
        rate_model = rate;
    endtask

    task automatic random_phase(logic [LR_W-1:0] rate, int count, bit calm, bit squeeze);
        drain();
        write_rate(rate);
        steady = calm;
        repeat (count) send(random_sample());
        if (squeeze)
            stall_request++;
    endtask

    initial
    begin
        feat_t lanes [NUM_INPUTS];
        foreach (weight_model[i])
            weight_model[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset learning rate. A zero sum predicts class 1, so target 0 is a miss.
        // These requests leave the bias at zero and lanes 0 to 3 untouched.
        lanes = '{default: '0};
        send(make_sample(lanes, 1'b0));
        send(make_sample(lanes, 1'b1));
        for (int i = 4; i < NUM_INPUTS; i++)
            lanes[i] = FEAT_MAX;
        send(make_sample(lanes, 1'b0));
        lanes = '{default: '0};
        send(make_sample(lanes, 1'b1));
        for (int i = 4; i < NUM_INPUTS; i++)
            lanes[i] = FEAT_MIN;
        send(make_sample(lanes, 1'b1));
        drain();

        // Full-scale rate: drive weight 0 into the low clamp and weight 2 into the high one.
        write_rate(16'hFFFF);
        lanes = '{default: '0};
        lanes[0] = FEAT_MAX;
        lanes[1] = -FEAT_MAX;
        send(make_sample(lanes, 1'b0));
        lanes[0] = feat_t'(200);
        lanes[1] = FEAT_MAX;
        send(make_sample(lanes, 1'b0));
        lanes = '{default: '0};
        lanes[2] = FEAT_MAX;
        lanes[3] = -FEAT_MAX;
        send(make_sample(lanes, 1'b1));
        lanes[2] = feat_t'(200);
        lanes[3] = FEAT_MAX;
        send(make_sample(lanes, 1'b1));
        lanes = '{default: FEAT_MAX};
        send(make_sample(lanes, 1'b1));
        send(make_sample(lanes, 1'b0));
        lanes = '{default: FEAT_MIN};
        send(make_sample(lanes, 1'b0));
        send(make_sample(lanes, 1'b1));
        drain();

        // Zero rate: misses are flagged but nothing moves.
        write_rate(16'd0);
        lanes = '{default: FEAT_MAX};
        send(make_sample(lanes, 1'b0));
        send(make_sample(lanes, 1'b1));
        lanes = '{default: '0};
        send(make_sample(lanes, 1'b0));
        send(make_sample(lanes, 1'b1));

        random_phase(16'd1, 250, 1'b0, 1'b0);
        random_phase(LR_W'($urandom_range(2, 65534)), 250, 1'b1, 1'b0);
        random_phase(16'hFFFF, 250, 1'b0, 1'b1);
        random_phase(16'd0, 120, 1'b0, 1'b0);
        random_phase(pcpt_pkg::LR_RESET, 250, 1'b0, 1'b0);
        random_phase(LR_W'($urandom_range(2, 65534)), 250, 1'b0, 1'b1);
        drain();
        repeat (16) @(posedge clk);

        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
